>>> rtl/rbst_pkg.sv
package rbst_pkg;

   localparam int CoordWidth = 32;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int FracBits   = 16;
   localparam int NumWidth   = CoordWidth + FracBits;   // |diff| << 16
   localparam int DivSteps   = NumWidth;                // one quotient bit per stage
   localparam int NumAxes    = 3;

   // abs stage + restoring steps + sign/saturate stage
   localparam int DivLatency  = DivSteps + 2;
   // diff stage + divider + order stage
   localparam int LaneLatency = DivLatency + 2;
   // lanes + merge stage
   localparam int CoreLatency = LaneLatency + 1;

   localparam logic signed [CoordWidth-1:0] TMin = {1'b1, {(CoordWidth-1){1'b0}}};
   localparam logic signed [CoordWidth-1:0] TMax = {1'b0, {(CoordWidth-1){1'b1}}};

   typedef struct packed {
      logic                         miss;
      logic signed [CoordWidth-1:0] t_near;
      logic signed [CoordWidth-1:0] t_far;
   } lane_res_type;

   typedef struct packed {
      logic                         hit;
      logic signed [CoordWidth-1:0] t_entry;
      logic signed [CoordWidth-1:0] t_exit;
   } core_res_type;

endpackage

>>> rtl/ray_box_slab_test_core.sv
// Ray / axis-aligned box slab test, one ray-box pair per beat.
// Depth: 53 pipeline stages plus output register,
// set by the 48-stage restoring divider, one quotient bit per stage, two per axis lane.
// Throughput: one beat per cycle while the skid slot is empty; a two-entry output register/skid
// keeps req_tready registered, so a new beat is taken while a finished result waits.
// Reset (synchronous, active high) clears valid bits only; datapath registers are not reset.
module ray_box_slab_test_core (
   input  logic         clock,
   input  logic         reset,
   // req_tdata, from bit 0 up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z (32 bits each)
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [383:0] req_tdata,
   // rsp_tdata, from bit 0 up: hit (1), t_entry (32), t_exit (32), 7 zero pad bits
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata
);

   localparam int CW = rbst_pkg::CoordWidth;
   localparam int CL = rbst_pkg::CoreLatency;

   // Whole pipeline moves together; it halts only while the skid slot holds a beat.
   logic enable;
   logic skid_valid_ff;
   assign enable     = !skid_valid_ff;
   assign req_tready = enable;

   logic accept;
   assign accept = req_tvalid && req_tready;

   // valid line that tracks beats through the datapath
   logic vld_ff [CL];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CL; i++) vld_ff[i] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= accept;
         for (int i = 1; i < CL; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   rbst_pkg::lane_res_type lane_res [rbst_pkg::NumAxes];

   for (genvar a = 0; a < rbst_pkg::NumAxes; a++) begin : g_lane
      rbst_lane u_lane (
         .clock   (clock),
         .enable  (enable),
         .origin  (req_tdata[a*CW +: CW]),
         .dir     (req_tdata[(3+a)*CW +: CW]),
         .box_min (req_tdata[(6+a)*CW +: CW]),
         .box_max (req_tdata[(9+a)*CW +: CW]),
         .res     (lane_res[a])
      );
   end

   rbst_pkg::core_res_type core_res;

   rbst_merge u_merge (
      .clock    (clock),
      .enable   (enable),
      .lane_res (lane_res),
      .res      (core_res)
   );

   // Output register plus one skid slot.
   logic                   out_valid_ff;
   rbst_pkg::core_res_type out_ff;
   rbst_pkg::core_res_type skid_ff;
   logic                   take;
   assign take = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (enable) begin
         if (take) begin
            out_valid_ff <= vld_ff[CL-1];
         end else if (vld_ff[CL-1]) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (take) out_ff <= core_res;
         else      skid_ff <= core_res;
      end else if (rsp_tready) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff.t_exit, out_ff.t_entry, out_ff.hit};

endmodule

>>> rtl/rbst_div_pipe.sv
// Pipelined signed divide: (num_diff << 16) / den, truncating, saturated to 32 bits.
module rbst_div_pipe (
   input  logic                                   clock,
   input  logic                                   enable,
   input  logic signed [rbst_pkg::DiffWidth-1:0]  num_diff,
   input  logic signed [rbst_pkg::CoordWidth-1:0] den,
   output logic signed [rbst_pkg::CoordWidth-1:0] quot
);

   localparam int CW = rbst_pkg::CoordWidth;
   localparam int NW = rbst_pkg::NumWidth;
   localparam int NS = rbst_pkg::DivSteps;

   logic [CW-1:0] rem_ff [NS+1];
   logic [NW-1:0] nq_ff  [NS+1];
   logic [CW-1:0] den_ff [NS+1];
   logic          neg_ff [NS+1];
   logic signed [CW-1:0] quot_ff;

   logic [rbst_pkg::DiffWidth-1:0] num_abs_in;
   logic [CW-1:0]                  den_abs_in;

   assign num_abs_in = num_diff[rbst_pkg::DiffWidth-1] ? -num_diff : num_diff;
   assign den_abs_in = den[CW-1] ? -den : den;

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= '0;
         nq_ff[0]  <= {num_abs_in[CW-1:0], {rbst_pkg::FracBits{1'b0}}};
         den_ff[0] <= den_abs_in;
         neg_ff[0] <= num_diff[rbst_pkg::DiffWidth-1] ^ den[CW-1];
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_step
      logic [CW:0]   sh;
      logic          ge;
      logic [CW:0]   sub;
      assign sh  = {rem_ff[k], nq_ff[k][NW-1]};
      assign sub = sh - {1'b0, den_ff[k]};
      assign ge  = sh >= {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= ge ? sub[CW-1:0] : sh[CW-1:0];
            nq_ff[k+1]  <= {nq_ff[k][NW-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   logic ovf;
   logic signed [CW-1:0] quot_in;
   assign ovf = |nq_ff[NS][NW-1:CW-1];

   always_comb begin
      if (neg_ff[NS]) begin
         quot_in = ovf ? rbst_pkg::TMin : -nq_ff[NS][CW-1:0];
      end else begin
         quot_in = ovf ? rbst_pkg::TMax : nq_ff[NS][CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

>>> rtl/rbst_lane.sv
// One axis: two slab quotients, ordered into near/far, zero-direction handling.
module rbst_lane (
   input  logic                                   clock,
   input  logic                                   enable,
   input  logic signed [rbst_pkg::CoordWidth-1:0] origin,
   input  logic signed [rbst_pkg::CoordWidth-1:0] dir,
   input  logic signed [rbst_pkg::CoordWidth-1:0] box_min,
   input  logic signed [rbst_pkg::CoordWidth-1:0] box_max,
   output rbst_pkg::lane_res_type                 res
);

   localparam int CW = rbst_pkg::CoordWidth;
   localparam int DW = rbst_pkg::DiffWidth;
   localparam int DL = rbst_pkg::DivLatency;

   logic signed [DW-1:0] dlo_ff, dhi_ff;
   logic signed [CW-1:0] dir_ff;
   logic                 zero_ff;
   logic                 inside_ff;
   logic                 zero_dly_ff   [DL];
   logic                 inside_dly_ff [DL];
   rbst_pkg::lane_res_type res_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         dlo_ff    <= DW'(box_min) - DW'(origin);
         dhi_ff    <= DW'(box_max) - DW'(origin);
         dir_ff    <= dir;
         zero_ff   <= (dir == '0);
         inside_ff <= (origin >= box_min) && (origin <= box_max);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_dly_ff[0]   <= zero_ff;
         inside_dly_ff[0] <= inside_ff;
         for (int i = 1; i < DL; i++) begin
            zero_dly_ff[i]   <= zero_dly_ff[i-1];
            inside_dly_ff[i] <= inside_dly_ff[i-1];
         end
      end
   end

   logic signed [CW-1:0] t1, t2;

   rbst_div_pipe u_div_lo (
      .clock    (clock),
      .enable   (enable),
      .num_diff (dlo_ff),
      .den      (dir_ff),
      .quot     (t1)
   );

   rbst_div_pipe u_div_hi (
      .clock    (clock),
      .enable   (enable),
      .num_diff (dhi_ff),
      .den      (dir_ff),
      .quot     (t2)
   );

   rbst_pkg::lane_res_type res_in;

   always_comb begin
      if (zero_dly_ff[DL-1]) begin
         // unconstrained axis: neutral bounds
         res_in.miss   = !inside_dly_ff[DL-1];
         res_in.t_near = rbst_pkg::TMin;
         res_in.t_far  = rbst_pkg::TMax;
      end else begin
         res_in.miss   = 1'b0;
         res_in.t_near = (t1 < t2) ? t1 : t2;
         res_in.t_far  = (t1 < t2) ? t2 : t1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

>>> rtl/rbst_merge.sv
// Combines the axis lanes: max of near, min of far, hit test.
module rbst_merge (
   input  logic                   clock,
   input  logic                   enable,
   input  rbst_pkg::lane_res_type lane_res [rbst_pkg::NumAxes],
   output rbst_pkg::core_res_type res
);

   rbst_pkg::core_res_type res_ff, res_in;

   always_comb begin
      logic signed [rbst_pkg::CoordWidth-1:0] entry;
      logic signed [rbst_pkg::CoordWidth-1:0] exit_t;
      logic                                   miss;
      entry  = rbst_pkg::TMin;
      exit_t = rbst_pkg::TMax;
      miss   = 1'b0;
      for (int a = 0; a < rbst_pkg::NumAxes; a++) begin
         if (lane_res[a].t_near > entry)  entry  = lane_res[a].t_near;
         if (lane_res[a].t_far  < exit_t) exit_t = lane_res[a].t_far;
         miss = miss | lane_res[a].miss;
      end
      res_in.hit     = !miss && (exit_t >= entry);
      res_in.t_entry = entry;
      res_in.t_exit  = exit_t;
   end

   always_ff @(posedge clock) begin
      if (enable) res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

>>> tb/ray_box_checker.sv
`timescale 1ns / 1ps
module ray_box_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [383:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   output int           fail_count,
   output int           pending
);

   rbst_pkg::core_res_type hit_queue[$];

   // one slab quotient: ((plane - org) << 16) / d, truncated, saturated
   function automatic logic signed [31:0] slab_quot(input logic signed [31:0] plane,
                                                    input logic signed [31:0] org,
                                                    input logic signed [31:0] d);
      longint diff;
      longint q;
      diff = longint'(plane) - longint'(org);
      q = (diff * 65536) / longint'(d);
      if (q > longint'(rbst_pkg::TMax)) return rbst_pkg::TMax;
      if (q < longint'(rbst_pkg::TMin)) return rbst_pkg::TMin;
      return q[31:0];
   endfunction

   function automatic rbst_pkg::core_res_type predict_hit(input logic [383:0] beat);
      rbst_pkg::core_res_type r;
      logic signed [31:0] o, d, lo, hi, t1, t2, tn, tf;
      logic miss;
      miss = 1'b0;
      r.t_entry = rbst_pkg::TMin;
      r.t_exit  = rbst_pkg::TMax;
      for (int a = 0; a < 3; a++) begin
         o  = beat[32*a +: 32];
         d  = beat[32*(3+a) +: 32];
         lo = beat[32*(6+a) +: 32];
         hi = beat[32*(9+a) +: 32];
         if (d == 0) begin
            if (!(o >= lo && o <= hi)) miss = 1'b1;
         end else begin
            t1 = slab_quot(lo, o, d);
            t2 = slab_quot(hi, o, d);
            tn = (t1 < t2) ? t1 : t2;
            tf = (t1 < t2) ? t2 : t1;
            if (tn > r.t_entry) r.t_entry = tn;
            if (tf < r.t_exit)  r.t_exit  = tf;
         end
      end
      r.hit = !miss && (r.t_exit >= r.t_entry);
      return r;
   endfunction

   always @(posedge clock) begin
      rbst_pkg::core_res_type want, got;
      if (reset) begin
         hit_queue.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (req_tvalid && req_tready)
            hit_queue.insert(hit_queue.size(), predict_hit(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.hit     = rsp_tdata[0];
            got.t_entry = rsp_tdata[32:1];
            got.t_exit  = rsp_tdata[64:33];
            if (hit_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = hit_queue.pop_front();
               if (want != got) begin
                  if (fail_count < 10)
                     $display("mismatch: hit %0d/%0d entry %h/%h exit %h/%h (exp/act)",
                              want.hit, got.hit, want.t_entry, got.t_entry,
                              want.t_exit, got.t_exit);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= hit_queue.size();
      end
   end
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [383:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   int           fail_count;
   int           pending;
   bit           quiet;      // no-idle stretch flag

   localparam int NumRandom = 1530;
   localparam int DrainCycles = 80;   // beyond the pipeline depth

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ray_box_slab_test_core u_dut (.*);

   ray_box_checker u_chk (.*);

   // random rsp stall, ~8%, none during quiet stretch
   always @(posedge clock)
      rsp_tready <= reset ? 1'b0 : (quiet || $urandom_range(99) >= 8);

   // edge-heavy coordinate pick
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return 32'h1;
         4: return 32'hffff_ffff;
         5, 6: return $urandom;
         default: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;  // small, +-8.0
      endcase
   endfunction

   // ray aimed roughly through a small box; some dir components zeroed
   function automatic logic [383:0] make_ray();
      logic [383:0] b;
      logic [31:0] c, h;
      for (int a = 0; a < 3; a++) begin
         c = $urandom_range(65535 * 16) - 65536 * 8;
         h = $urandom_range(65536 * 4);
         b[32*a +: 32]     = $urandom_range(65536 * 32) - 65536 * 16;
         b[32*(3+a) +: 32] = ($urandom_range(7) == 0) ? 32'h0 : c - b[32*a +: 32];
         b[32*(6+a) +: 32] = c - h;
         b[32*(9+a) +: 32] = c + h;
      end
      return b;
   endfunction

   // one beat; holds valid until accepted, idles ~8% unless quiet
   task automatic send_beat(input logic [383:0] b);
      while (!quiet && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [383:0] b;
      quiet = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero dirs inside/outside, inverted box, all-unconstrained
      send_beat('0);                                     // all zero: origin on slabs
      send_beat({384{1'b1}});
      for (int k = 0; k < 12; k++) begin
         b = '0;
         b[32*k +: 32] = 32'h8000_0000;
         send_beat(b);
         b[32*k +: 32] = 32'h7fff_ffff;
         send_beat(b);
      end
      b = '0;
      for (int a = 0; a < 3; a++) begin
         b[32*(3+a) +: 32] = 32'h0000_0001;             // tiny dir -> saturation
         b[32*(6+a) +: 32] = 32'h8000_0000;
         b[32*(9+a) +: 32] = 32'h7fff_ffff;
      end
      send_beat(b);
      b[32*6 +: 32] = 32'h0001_0000;                     // inverted x slab
      b[32*9 +: 32] = 32'hffff_0000;
      send_beat(b);

      // let the pipe drain fully before the random part
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);

      for (int n = 0; n < NumRandom; n++) begin
         quiet = (n >= 600 && n < 800);
         if ($urandom_range(9) < 6) b = make_ray();
         else for (int k = 0; k < 12; k++) b[32*k +: 32] = pick_coord();
         send_beat(b);
      end
      req_tvalid <= 1'b0;
      quiet = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end
endmodule

>>> sim.f
rtl/rbst_pkg.sv
rtl/rbst_div_pipe.sv
rtl/rbst_lane.sv
rtl/rbst_merge.sv
rtl/ray_box_slab_test_core.sv
tb/ray_box_checker.sv
tb/tb.sv
